// File: hw/rtl/vir_pkg.sv
// ----------------------------------------------------------------------------
// Voxel interior removal package
// Shared sizes, command and register codes, and the control structs that
// pass between the top level, the delay chain and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package vir_pkg;

    // Largest volume the window is sized for
    localparam int MAX_X = 64;
    localparam int MAX_Y = 64;
    localparam int MAX_Z = 64;

    // Field widths
    localparam int DIM_W = 7;
    localparam int POS_W = 6;

    // Stream widths
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 24;
    localparam int OUT_PAD_W  = OUT_DATA_W - 3 * POS_W - 2;

    // Delay chain sizing: the longest segment is one plane less one row
    localparam int PLANE_MAX  = MAX_Y * MAX_Z;
    localparam int DLY_W      = $clog2(PLANE_MAX);
    localparam int CELL_DEPTH = PLANE_MAX;
    localparam int PTR_W      = $clog2(CELL_DEPTH);
    localparam int N_CELLS    = 6;

    // Request kinds
    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // Register map
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_SIZE_X = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

    localparam logic [DIM_W-1:0] DIM_X_MAX = DIM_W'(MAX_X);
    localparam logic [DIM_W-1:0] DIM_Y_MAX = DIM_W'(MAX_Y);
    localparam logic [DIM_W-1:0] DIM_Z_MAX = DIM_W'(MAX_Z);

    localparam logic [DLY_W-1:0] DLY_ROW_RST   = DLY_W'(MAX_Z - 1);
    localparam logic [DLY_W-1:0] DLY_PLANE_RST = DLY_W'(MAX_Z * (MAX_Y - 1));

    typedef struct packed {
        logic             shift;
        logic             restart;
        logic [DLY_W-1:0] delay;
    } cell_ctl_t;

    typedef struct packed {
        logic             shift;
        logic             restart;
        logic [DLY_W-1:0] dly_row;
        logic [DLY_W-1:0] dly_plane;
    } chain_ctl_t;

    typedef struct packed {
        logic up_x;
        logic up_y;
        logic up_z;
        logic centre;
        logic dn_z;
        logic dn_y;
        logic dn_x;
    } taps_t;

    // Zero reads as one, anything above the limit as the limit
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] lim);
        logic [DIM_W-1:0] r;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (v > lim)
        begin
            r = lim;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/vir_cell.sv
// ----------------------------------------------------------------------------
// Delay cell
// One link of the voxel window: delays its input bit by a programmable
// number of shifts, using a circular bit buffer for delays of two or more.
// ----------------------------------------------------------------------------
`default_nettype none

module vir_cell
    import vir_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cell_ctl_t ctl,
    input  wire logic      din,
    output logic           dout
);

    logic             buf_mem [CELL_DEPTH];
    logic [PTR_W-1:0] ptr_reg;
    logic [PTR_W-1:0] ptr_next;
    logic [PTR_W-1:0] last_idx;
    logic             rd_reg;
    logic             byp_reg;

    // Buffer length is delay - 1; the read register adds the last step
    assign last_idx = PTR_W'(ctl.delay - DLY_W'(2));

    always_comb
    begin
        if (ctl.restart || (ctl.delay < DLY_W'(2)))
        begin
            ptr_next = '0;
        end
        else if (ctl.shift)
        begin
            ptr_next = (ptr_reg == last_idx) ? '0 : ptr_reg + PTR_W'(1);
        end
        else
        begin
            ptr_next = ptr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
        end
        else
        begin
            ptr_reg <= ptr_next;
        end
    end

    // Read the oldest bit, then overwrite it with the new one
    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            buf_mem[ptr_reg] <= din;
            rd_reg           <= buf_mem[ptr_reg];
            byp_reg          <= din;
        end
    end

    always_comb
    begin
        if (ctl.delay == '0)
        begin
            dout = din;
        end
        else if (ctl.delay == DLY_W'(1))
        begin
            dout = byp_reg;
        end
        else
        begin
            dout = rd_reg;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/vir_chain.sv
// ----------------------------------------------------------------------------
// Window delay chain
// Row of delay cells that holds two planes plus one voxel and exposes the
// centre voxel and its six face neighbours as taps.
// ----------------------------------------------------------------------------
`default_nettype none

module vir_chain
    import vir_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire chain_ctl_t ctl,
    input  wire logic       din,
    output taps_t           taps
);

    logic link [N_CELLS+1];

    assign link[0] = din;

    // Segments from the newest bit: plane-row, row-1, 1, 1, row-1, plane-row
    for (genvar i = 0; i < N_CELLS; i++)
    begin : g_cell
        cell_ctl_t cc;

        assign cc.shift   = ctl.shift;
        assign cc.restart = ctl.restart;
        assign cc.delay   = ((i == 0) || (i == N_CELLS - 1)) ? ctl.dly_plane :
                            ((i == 1) || (i == N_CELLS - 2)) ? ctl.dly_row   :
                                                               DLY_W'(1);

        vir_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (cc),
            .din   (link[i]),
            .dout  (link[i+1])
        );
    end

    assign taps.up_x   = link[0];
    assign taps.up_y   = link[1];
    assign taps.up_z   = link[2];
    assign taps.centre = link[3];
    assign taps.dn_z   = link[4];
    assign taps.dn_y   = link[5];
    assign taps.dn_x   = link[6];

endmodule

`default_nettype wire

// File: hw/rtl/voxel_interior_removal_unit.sv
// ----------------------------------------------------------------------------
// Voxel interior removal unit
// Streams a voxel volume in raster order and clears every interior voxel
// whose six face neighbours are all filled.
// ----------------------------------------------------------------------------
// The unit takes one request per clock cycle while s_tready is high, pushes
// and drains alike, and produces each result in the same cycle that the
// request is accepted; it is registered before the master side sees it.
// Push occupancy bits in raster order (x outermost, z innermost). A voxel's
// result is given on the push that delivers its x+1 neighbour, so the first
// plane of pushes gives nothing; after the last push, send one drain request
// per voxel of the final plane. Pushes beyond the volume, and drains before
// the last push or with nothing pending, are dropped silently. The window is
// a chain of six delay cells (two planes plus one voxel, each cell a
// 4096-bit circular buffer with one read and one write per shift), and every
// request that is not dropped moves it by one step. The buffers need no
// clearing after reset: only neighbours of border voxels can read stale
// bits, and those are never used. Writing a size register restarts the
// volume; write it only when the unit is idle. A two-entry output stage
// (output register plus skid) holds one extra result while the master side
// stalls; s_tready drops only when both entries hold a result.
// ----------------------------------------------------------------------------
`default_nettype none

module voxel_interior_removal_unit
    import vir_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // [0] occupied, rest zero
    input  wire logic [0:0]            s_tuser,   // [0] command

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,   // [5:0] pos_x, [11:6] pos_y,
                                                  // [17:12] pos_z, [18] filled,
                                                  // [19] hollowed, rest zero
    output logic                       m_tlast,

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [REG_IDX_W-1:0]  cfg_index,
    input  wire logic [DIM_W-1:0]      cfg_data
);

    // ------------------------------------------------------------------
    // Size registers and derived delays
    // ------------------------------------------------------------------
    logic [DIM_W-1:0]   nx_reg, nx_next;
    logic [DIM_W-1:0]   ny_reg, ny_next;
    logic [DIM_W-1:0]   nz_reg, nz_next;
    logic [DLY_W-1:0]   dly_row_reg, dly_row_next;
    logic [DLY_W-1:0]   dly_plane_reg, dly_plane_next;
    logic [2*DIM_W-1:0] plane_prod;
    logic               cfg_wr;
    logic               cfg_hit;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    // Decode the register write; unknown indexes leave everything alone
    always_comb
    begin
        nx_next = nx_reg;
        ny_next = ny_reg;
        nz_next = nz_reg;
        cfg_hit = 1'b0;
        if (cfg_wr)
        begin
            unique case (cfg_index)
                REG_SIZE_X:
                begin
                    nx_next = clamp_dim(cfg_data, DIM_X_MAX);
                    cfg_hit = 1'b1;
                end
                REG_SIZE_Y:
                begin
                    ny_next = clamp_dim(cfg_data, DIM_Y_MAX);
                    cfg_hit = 1'b1;
                end
                REG_SIZE_Z:
                begin
                    nz_next = clamp_dim(cfg_data, DIM_Z_MAX);
                    cfg_hit = 1'b1;
                end
                default:
                begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    // Row segment is nz-1, plane segment is nz*(ny-1); both set with the size
    assign plane_prod     = (2*DIM_W)'(nz_next) * (2*DIM_W)'(ny_next - DIM_W'(1));
    assign dly_row_next   = DLY_W'(nz_next - DIM_W'(1));
    assign dly_plane_next = DLY_W'(plane_prod);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nx_reg        <= DIM_X_MAX;
            ny_reg        <= DIM_Y_MAX;
            nz_reg        <= DIM_Z_MAX;
            dly_row_reg   <= DLY_ROW_RST;
            dly_plane_reg <= DLY_PLANE_RST;
        end
        else
        begin
            nx_reg        <= nx_next;
            ny_reg        <= ny_next;
            nz_reg        <= nz_next;
            dly_row_reg   <= dly_row_next;
            dly_plane_reg <= dly_plane_next;
        end
    end

    // ------------------------------------------------------------------
    // Request decode
    // ------------------------------------------------------------------
    logic             accept;
    logic             is_push;
    logic             do_push;
    logic             do_drain;
    logic             emit;
    logic             shift;
    logic             din;

    logic [POS_W-1:0] ix_reg, ix_next;
    logic [POS_W-1:0] iy_reg, iy_next;
    logic [POS_W-1:0] iz_reg, iz_next;
    logic             in_done_reg, in_done_next;
    logic [POS_W-1:0] ox_reg, ox_next;
    logic [POS_W-1:0] oy_reg, oy_next;
    logic [POS_W-1:0] oz_reg, oz_next;
    logic             out_done_reg, out_done_next;

    logic             ix_end, iy_end, iz_end;
    logic             ox_end, oy_end, oz_end;

    assign accept  = s_tvalid && s_tready;
    assign is_push = (s_tuser[0] == CMD_PUSH);

    // Drop pushes past the volume and drains with nothing pending
    assign do_push  = accept && is_push && !in_done_reg;
    assign do_drain = accept && (s_tuser[0] == CMD_DRAIN) && in_done_reg && !out_done_reg;

    // A push from the second plane on completes the voxel one plane behind
    assign emit  = (do_push && (ix_reg != '0)) || do_drain;
    assign shift = do_push || do_drain;
    assign din   = do_push ? s_tdata[0] : 1'b0;

    assign ix_end = ({1'b0, ix_reg} == (nx_reg - DIM_W'(1)));
    assign iy_end = ({1'b0, iy_reg} == (ny_reg - DIM_W'(1)));
    assign iz_end = ({1'b0, iz_reg} == (nz_reg - DIM_W'(1)));
    assign ox_end = ({1'b0, ox_reg} == (nx_reg - DIM_W'(1)));
    assign oy_end = ({1'b0, oy_reg} == (ny_reg - DIM_W'(1)));
    assign oz_end = ({1'b0, oz_reg} == (nz_reg - DIM_W'(1)));

    // Advance the push position in raster order
    always_comb
    begin
        ix_next      = ix_reg;
        iy_next      = iy_reg;
        iz_next      = iz_reg;
        in_done_next = in_done_reg;
        if (cfg_hit)
        begin
            ix_next      = '0;
            iy_next      = '0;
            iz_next      = '0;
            in_done_next = 1'b0;
        end
        else if (do_push)
        begin
            in_done_next = ix_end && iy_end && iz_end;
            if (!iz_end)
            begin
                iz_next = iz_reg + POS_W'(1);
            end
            else
            begin
                iz_next = '0;
                if (!iy_end)
                begin
                    iy_next = iy_reg + POS_W'(1);
                end
                else
                begin
                    iy_next = '0;
                    ix_next = ix_reg + POS_W'(1);
                end
            end
        end
    end

    // Advance the result position in raster order
    always_comb
    begin
        ox_next       = ox_reg;
        oy_next       = oy_reg;
        oz_next       = oz_reg;
        out_done_next = out_done_reg;
        if (cfg_hit)
        begin
            ox_next       = '0;
            oy_next       = '0;
            oz_next       = '0;
            out_done_next = 1'b0;
        end
        else if (emit)
        begin
            out_done_next = ox_end && oy_end && oz_end;
            if (!oz_end)
            begin
                oz_next = oz_reg + POS_W'(1);
            end
            else
            begin
                oz_next = '0;
                if (!oy_end)
                begin
                    oy_next = oy_reg + POS_W'(1);
                end
                else
                begin
                    oy_next = '0;
                    ox_next = ox_reg + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ix_reg       <= '0;
            iy_reg       <= '0;
            iz_reg       <= '0;
            in_done_reg  <= 1'b0;
            ox_reg       <= '0;
            oy_reg       <= '0;
            oz_reg       <= '0;
            out_done_reg <= 1'b0;
        end
        else
        begin
            ix_reg       <= ix_next;
            iy_reg       <= iy_next;
            iz_reg       <= iz_next;
            in_done_reg  <= in_done_next;
            ox_reg       <= ox_next;
            oy_reg       <= oy_next;
            oz_reg       <= oz_next;
            out_done_reg <= out_done_next;
        end
    end

    // ------------------------------------------------------------------
    // Window
    // ------------------------------------------------------------------
    chain_ctl_t chain_ctl;
    taps_t      taps;

    assign chain_ctl.shift     = shift;
    assign chain_ctl.restart   = cfg_hit;
    assign chain_ctl.dly_row   = dly_row_reg;
    assign chain_ctl.dly_plane = dly_plane_reg;

    vir_chain u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (chain_ctl),
        .din   (din),
        .taps  (taps)
    );

    // ------------------------------------------------------------------
    // Classify the voxel at the result position
    // ------------------------------------------------------------------
    logic                  border;
    logic                  removed;
    logic                  res_filled;
    logic [OUT_DATA_W-1:0] res_data;
    logic                  res_last;

    assign border = (ox_reg == '0) || ox_end ||
                    (oy_reg == '0) || oy_end ||
                    (oz_reg == '0) || oz_end;

    assign removed = !border && taps.centre &&
                     taps.up_x && taps.dn_x &&
                     taps.up_y && taps.dn_y &&
                     taps.up_z && taps.dn_z;

    assign res_filled = taps.centre && !removed;
    assign res_data   = {{OUT_PAD_W{1'b0}}, removed, res_filled, oz_reg, oy_reg, ox_reg};
    assign res_last   = ox_end && oy_end && oz_end;

    // ------------------------------------------------------------------
    // Output register with skid
    // ------------------------------------------------------------------
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic                  out_last_reg, out_last_next;
    logic                  skid_valid_reg, skid_valid_next;
    logic [OUT_DATA_W-1:0] skid_data_reg, skid_data_next;
    logic                  skid_last_reg, skid_last_next;
    logic                  out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        skid_last_next  = skid_last_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                // Move the held result forward, park a new one behind it
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                out_last_next   = skid_last_reg;
                skid_valid_next = emit;
                skid_data_next  = res_data;
                skid_last_next  = res_last;
            end
            else
            begin
                out_valid_next = emit;
                out_data_next  = res_data;
                out_last_next  = res_last;
            end
        end
        else if (emit)
        begin
            // Output stalled: hold the new result in the skid entry
            skid_valid_next = 1'b1;
            skid_data_next  = res_data;
            skid_last_next  = res_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        out_last_reg  <= out_last_next;
        skid_data_reg <= skid_data_next;
        skid_last_reg <= skid_last_next;
    end

    assign s_tready = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// File: hw/rtl/vir_checker.sv
// ----------------------------------------------------------------------------
// Voxel interior removal port checker
// Watches the top-level ports for result and flow-control slips.
// ----------------------------------------------------------------------------
`default_nettype none

module vir_checker
    import vir_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_tready,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [OUT_DATA_W-1:0] m_tdata,
    input wire logic                  m_tlast
);

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // Reset empties the output stage by the next edge
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("result shown during reset");

    // Requests only stall while a result is waiting
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("request stalled with empty output");

    // A voxel is never both kept and removed
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[3*POS_W] && m_tdata[3*POS_W+1]))
        else $error("filled and hollowed both set");

    // Removed voxels never lie on a low border face
    a_border: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3*POS_W+1] |->
            (m_tdata[POS_W-1:0] != '0) && (m_tdata[2*POS_W-1:POS_W] != '0) &&
            (m_tdata[3*POS_W-1:2*POS_W] != '0))
        else $error("border voxel reported as hollowed");

endmodule

bind voxel_interior_removal_unit vir_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Voxel interior removal unit testbench
// Streams small voxel volumes through the unit under random back-pressure,
// predicts every result from an own model of the six-neighbour test and
// checks each result field by field, in order, as it leaves the master side.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    import vir_pkg::*;

    // Register index that the unit does not decode: a write must change nothing
    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam int HOLD_CYCLES  = 150;   // long receiver hold-off
    localparam int SETTLE_GAP   = 8;     // quiet cycles before a register write
    localparam int STALL_LIMIT  = 3000;  // cycles with no handshake at all
    localparam int RAND_TARGET  = 550;   // useful requests in the random part
    localparam int VOL_MAX      = MAX_X * MAX_Y * MAX_Z;

    typedef struct packed {
        logic cmd;
        logic occ;
    } voxel_req_t;

    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [POS_W-1:0] z;
        logic             filled;
        logic             hollowed;
        logic             final_voxel;
    } voxel_res_t;

    // ------------------------------------------------------------------------
    // Clock, reset and the unit's ports
    // ------------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;   // [0] occupied, rest zero
    logic [0:0]            s_tuser  = '0;   // [0] command

    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;         // [5:0] pos_x, [11:6] pos_y,
                                            // [17:12] pos_z, [18] filled,
                                            // [19] hollowed, rest zero
    logic                  m_tlast;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [REG_IDX_W-1:0]  cfg_index = '0;
    logic [DIM_W-1:0]      cfg_data  = '0;

    initial
    begin
        forever #6 clk = ~clk;
    end

    voxel_interior_removal_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Own copy of the unit's state: the three size registers, the push and
    // result counters, and the occupancy of the current volume indexed by
    // raster position. Only positions already pushed in this volume are read.
    // ------------------------------------------------------------------------
    logic [DIM_W-1:0] size_x_reg = DIM_X_MAX;
    logic [DIM_W-1:0] size_y_reg = DIM_Y_MAX;
    logic [DIM_W-1:0] size_z_reg = DIM_Z_MAX;
    int               voxels_in  = 0;
    int               voxels_out = 0;
    bit               occ_map [0:VOL_MAX-1];

    voxel_req_t request_fifo[$];     // requests waiting for the driver
    voxel_res_t expected_voxels[$];  // predicted results, oldest first

    // Stimulus controls, changed by the sequence on falling edges only
    bit idle_on  = 1'b1;   // random bursts of idling allowed
    bit calm     = 1'b0;   // final stretch: no idling on either side
    bit hold_req = 1'b0;   // toggle to ask the receiver for a long hold-off
    bit hold_ack = 1'b0;

    int errors          = 0;
    int results_checked = 0;
    int hollowed_seen   = 0;
    int dropped_reqs    = 0;
    int volumes_run     = 0;
    int useful_requests = 0;
    int quiet_cycles    = 0;

    // Zero reads as one, anything above the window limit as the limit
    function automatic int eff_dim(input logic [DIM_W-1:0] v, input int lim);
        int r;
        r = int'(v);
        if (r == 0)
        begin
            r = 1;
        end
        else if (r > lim)
        begin
            r = lim;
        end
        return r;
    endfunction

    // Result for raster position n of the current volume
    function automatic voxel_res_t voxel_result(input int n);
        voxel_res_t r;
        int         nx;
        int         ny;
        int         nz;
        int         plane;
        int         px;
        int         py;
        int         pz;
        bit         inner;
        bit         buried;
        nx     = eff_dim(size_x_reg, MAX_X);
        ny     = eff_dim(size_y_reg, MAX_Y);
        nz     = eff_dim(size_z_reg, MAX_Z);
        plane  = ny * nz;
        px     = n / plane;
        py     = (n % plane) / nz;
        pz     = n % nz;
        inner  = (px > 0) && (px + 1 < nx) && (py > 0) && (py + 1 < ny) &&
                 (pz > 0) && (pz + 1 < nz);
        // Neighbours are only looked at for interior voxels, so every index
        // below stays inside the part of the volume pushed so far
        buried = inner && occ_map[n - plane] && occ_map[n + plane] &&
                 occ_map[n - nz] && occ_map[n + nz] &&
                 occ_map[n - 1] && occ_map[n + 1];
        r.x           = POS_W'(px);
        r.y           = POS_W'(py);
        r.z           = POS_W'(pz);
        r.hollowed    = occ_map[n] && buried;
        r.filled      = occ_map[n] && !buried;
        r.final_voxel = (n + 1 == nx * plane);
        return r;
    endfunction

    task automatic queue_next_result();
        voxel_res_t r;
        r = voxel_result(voxels_out);
        voxels_out++;
        if (r.hollowed)
        begin
            hollowed_seen++;
        end
        expected_voxels.push_back(r);
    endtask

    // Advance the model by one accepted request
    task automatic apply_request(input logic cmd, input logic occ);
        int plane;
        int total;
        plane = eff_dim(size_y_reg, MAX_Y) * eff_dim(size_z_reg, MAX_Z);
        total = eff_dim(size_x_reg, MAX_X) * plane;
        if (cmd == CMD_PUSH)
        begin
            if (voxels_in >= total)
            begin
                dropped_reqs++;     // volume complete: push is dropped
            end
            else
            begin
                occ_map[voxels_in] = occ;
                voxels_in++;
                if (voxels_in > plane && voxels_out < total)
                begin
                    queue_next_result();
                end
            end
        end
        else if (voxels_in < total || voxels_out >= total)
        begin
            dropped_reqs++;         // early or surplus drain
        end
        else
        begin
            queue_next_result();
        end
    endtask

    task automatic report(input string what, input int got, input int want);
        if (errors < 40)
        begin
            $display("mismatch on %s in result %0d: got %0d, expected %0d",
                     what, results_checked, got, want);
        end
        errors++;
    endtask

    task automatic check_result();
        voxel_res_t want;
        if (expected_voxels.size() == 0)
        begin
            report("unexpected result", int'(m_tdata), -1);
            return;
        end
        want = expected_voxels.pop_front();
        if (m_tdata[POS_W-1:0] != want.x)
        begin
            report("pos_x", int'(m_tdata[POS_W-1:0]), int'(want.x));
        end
        if (m_tdata[2*POS_W-1:POS_W] != want.y)
        begin
            report("pos_y", int'(m_tdata[2*POS_W-1:POS_W]), int'(want.y));
        end
        if (m_tdata[3*POS_W-1:2*POS_W] != want.z)
        begin
            report("pos_z", int'(m_tdata[3*POS_W-1:2*POS_W]), int'(want.z));
        end
        if (m_tdata[3*POS_W] !== want.filled)
        begin
            report("filled", int'(m_tdata[3*POS_W]), int'(want.filled));
        end
        if (m_tdata[3*POS_W+1] !== want.hollowed)
        begin
            report("hollowed", int'(m_tdata[3*POS_W+1]), int'(want.hollowed));
        end
        if (m_tdata[OUT_DATA_W-1:3*POS_W+2] !== '0)
        begin
            report("padding", int'(m_tdata[OUT_DATA_W-1:3*POS_W+2]), 0);
        end
        if (m_tlast !== want.final_voxel)
        begin
            report("last", int'(m_tlast), int'(want.final_voxel));
        end
        results_checked++;
    endtask

    // ------------------------------------------------------------------------
    // Driver: present queued requests on the slave side. Hold the request
    // until it is taken; between requests insert random bursts of idling.
    // Each accepted request is passed to the model at the edge that takes it.
    // ------------------------------------------------------------------------
    int         gap_left = 0;
    voxel_req_t next_req;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            gap_left  = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                apply_request(s_tuser[0], s_tdata[0]);
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (!calm && idle_on && $urandom_range(0, 5) == 0)
                begin
                    gap_left = $urandom_range(0, 8);   // start a burst of idling
                    s_tvalid <= 1'b0;
                end
                else if (request_fifo.size() != 0)
                begin
                    next_req = request_fifo.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{(IN_DATA_W-1){1'b0}}, next_req.occ};
                    s_tuser  <= next_req.cmd;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check every result taken on the master side and drive
    // m_tready. Random stalls come in bursts; on request, hold off for a long
    // stretch so that the output stage fills and the slave side backs up.
    // ------------------------------------------------------------------------
    int stall_left = 0;
    int hold_left  = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                check_result();
            end
            if (hold_req != hold_ack)
            begin
                hold_ack  = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (!calm && idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 8);
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: count cycles in which no handshake completes anywhere
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("[voxel_interior_removal_unit] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sequence helpers
    // ------------------------------------------------------------------------
    task automatic add_request(input logic cmd, input logic occ);
        voxel_req_t r;
        r.cmd = cmd;
        r.occ = occ;
        request_fifo.push_back(r);
    endtask

    // Wait until every queued request is taken and every result has arrived
    task automatic drain_all();
        do
        begin
            @(negedge clk);
        end
        while (request_fifo.size() != 0 || s_tvalid || expected_voxels.size() != 0);
    endtask

    // Drain, then leave a quiet gap before the next step
    task automatic settle();
        drain_all();
        repeat (SETTLE_GAP) @(negedge clk);
    endtask

    // One register write; the model takes it at the accepting edge
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
                             input logic [DIM_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        // Only decoded indexes change a size and restart the volume
        if (idx == REG_SIZE_X || idx == REG_SIZE_Y || idx == REG_SIZE_Z)
        begin
            if (idx == REG_SIZE_X)
            begin
                size_x_reg = val;
            end
            else if (idx == REG_SIZE_Y)
            begin
                size_y_reg = val;
            end
            else
            begin
                size_z_reg = val;
            end
            voxels_in  = 0;
            voxels_out = 0;
        end
    endtask

    task automatic set_sizes(input int sx, input int sy, input int sz);
        settle();
        write_reg(REG_SIZE_X, DIM_W'(sx));
        write_reg(REG_SIZE_Y, DIM_W'(sy));
        write_reg(REG_SIZE_Z, DIM_W'(sz));
        @(negedge clk);
    endtask

    // Queue one volume at the present sizes. Noise adds early drains, extra
    // pushes and surplus drains; a cut volume stops partway and is never
    // drained; a split volume pauses the sender halfway until all results
    // so far have come back.
    task automatic queue_volume(input int dens, input bit noisy, input bit cut,
                                input bit split);
        int plane;
        int total;
        int stop;
        plane = eff_dim(size_y_reg, MAX_Y) * eff_dim(size_z_reg, MAX_Z);
        total = eff_dim(size_x_reg, MAX_X) * plane;
        stop  = cut ? $urandom_range(1, total) : total;
        volumes_run++;
        for (int i = 0; i < stop; i++)
        begin
            if (split && i == total / 2)
            begin
                drain_all();
            end
            if (noisy && $urandom_range(0, 11) == 0)
            begin
                add_request(CMD_DRAIN, 1'($urandom_range(0, 1)));
            end
            add_request(CMD_PUSH, 1'($urandom_range(0, 99) < dens));
        end
        useful_requests += stop;
        if (!cut)
        begin
            for (int j = 0; j < plane; j++)
            begin
                if (noisy && $urandom_range(0, 7) == 0)
                begin
                    add_request(CMD_PUSH, 1'($urandom_range(0, 1)));
                end
                add_request(CMD_DRAIN, 1'($urandom_range(0, 1)));
            end
            if (noisy)
            begin
                repeat ($urandom_range(1, 3))
                begin
                    add_request(CMD_DRAIN, 1'($urandom_range(0, 1)));
                end
            end
            useful_requests += plane;
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int dens;
        int wait_left;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Sizes of zero read as one: a single-voxel volume. Drain too early,
        // push, push once more past the end, drain the result, drain again.
        set_sizes(0, 0, 0);
        add_request(CMD_DRAIN, 1'b1);
        add_request(CMD_PUSH,  1'b1);
        add_request(CMD_PUSH,  1'b0);
        add_request(CMD_DRAIN, 1'b0);
        add_request(CMD_DRAIN, 1'b1);

        // Undecoded index must leave sizes and stream alone
        settle();
        write_reg(REG_UNUSED, 7'd127);

        // Start a 2x2x2 volume, abandon it, restart it with a write
        set_sizes(2, 2, 2);
        add_request(CMD_PUSH, 1'b1);
        add_request(CMD_PUSH, 1'b0);
        add_request(CMD_PUSH, 1'b1);
        settle();
        write_reg(REG_SIZE_X, 7'd2);
        @(negedge clk);
        for (int i = 0; i < 8; i++)
        begin
            add_request(CMD_PUSH, (i == 5) ? 1'b0 : 1'b1);
        end
        repeat (4) add_request(CMD_DRAIN, 1'b0);

        // Random part: shaped volumes first, then random small ones
        useful_requests = 0;

        set_sizes(3, 3, 3);             // solid cube: only the centre hollows
        queue_volume(100, 1'b0, 1'b0, 1'b0);

        set_sizes(127, 1, 1);           // x above the limit reads as 64
        queue_volume(70, 1'b1, 1'b0, 1'b0);

        set_sizes(1, 64, 1);            // one plane of 64 rows, no idling
        @(negedge clk);
        idle_on = 1'b0;
        queue_volume(60, 1'b0, 1'b0, 1'b0);

        set_sizes(1, 1, 127);           // z clamps to 64
        @(negedge clk);
        idle_on = 1'b1;
        queue_volume(70, 1'b1, 1'b0, 1'b0);

        // Long receiver hold-off while the sender keeps offering
        set_sizes(4, 4, 4);
        hold_req = ~hold_req;
        queue_volume(100, 1'b0, 1'b0, 1'b0);

        // Sender pauses halfway until every result so far has come
        set_sizes(4, 4, 5);
        queue_volume(95, 1'b0, 1'b0, 1'b1);

        while (useful_requests < RAND_TARGET)
        begin
            set_sizes($urandom_range(0, 5), $urandom_range(0, 5), $urandom_range(0, 6));
            idle_on = ($urandom_range(0, 3) != 0);
            if (useful_requests > RAND_TARGET - 100)
            begin
                calm = 1'b1;
            end
            case ($urandom_range(0, 2))
                0:       dens = 50;
                1:       dens = 85;
                default: dens = 100;
            endcase
            queue_volume(dens, $urandom_range(0, 2) == 0, $urandom_range(0, 7) == 0,
                         1'b0);
        end

        // Let the last requests go, then wait for outstanding results
        do
        begin
            @(negedge clk);
        end
        while (request_fifo.size() != 0 || s_tvalid);
        wait_left = 400;
        while (expected_voxels.size() != 0 && wait_left > 0)
        begin
            @(negedge clk);
            wait_left--;
        end
        repeat (20) @(negedge clk);
        if (expected_voxels.size() != 0)
        begin
            report("results never delivered", 0, expected_voxels.size());
        end

        $display("ran %0d volumes, %0d results checked (%0d hollowed), %0d requests dropped",
                 volumes_run, results_checked, hollowed_seen, dropped_reqs);
        $display("sizes swept from clamped zero to clamped 127, with stalls and hold-offs");
        if (errors == 0)
        begin
            $display("[voxel_interior_removal_unit] OK");
        end
        else
        begin
            $display("[voxel_interior_removal_unit] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
